// ===== rtl/smv_pkg.sv =====
// ----------------------------------------------------------------------------
// smv_pkg: shared types and constants for the sparse matrix-vector block
// Field widths, operation codes, register indexes and the control word that
// travels with each item from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package smv_pkg;

   // Fixed field widths of the stream and configuration ports.
   localparam int INDEX_W     = 10;
   localparam int FIELD_W     = 32;
   localparam int OP_W        = 2;
   localparam int ROW_IDX_W   = 16;
   localparam int ROWS_W      = 17;
   localparam int COLS_W      = 11;
   localparam int ACC_W       = 64;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 17;

   // Depth of the queue between front and back end.
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;
   localparam int FIFO_CNT_W  = 3;

   // Operation codes carried in req_tuser.
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_NONZERO = 2'd1;
   localparam logic [OP_W-1:0] OP_EMPTY   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS = 1'd1;

   // Classified item as it travels through the queue.
   typedef struct packed {
      logic is_load;   // write the vector store
      logic is_mac;    // multiply-accumulate a nonzero
      logic col_ok;    // column is inside the vector in use
      logic row_done;  // this item closes the current row
   } item_ctl_type;

endpackage

// ===== rtl/smv_front.sv =====
// ----------------------------------------------------------------------------
// smv_front: input classification
// Decodes each request transfer, checks its index against the store depth and
// the column count in use, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module smv_front
   import smv_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int AW          = 10,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] index, [41:10] value, rest zero
   input  logic [OP_W-1:0]        req_tuser,   // [1:0] operation
   input  logic                   req_tlast,   // row_end
   input  logic [COLS_W-1:0]      num_cols,
   input  logic                   fifo_full,
   output logic                   push,
   output item_ctl_type           push_ctl,
   output logic [AW-1:0]          push_addr,
   output logic [VALUE_WIDTH-1:0] push_value
);

   localparam logic [31:0] MaxCols = 32'(MAX_COLS);

   logic [INDEX_W-1:0] idx;
   logic               in_store;
   logic               keep;

   assign idx        = req_tdata[INDEX_W-1:0];
   assign push_value = req_tdata[INDEX_W +: VALUE_WIDTH];
   assign push_addr  = AW'(idx);
   assign in_store   = 32'(idx) < MaxCols;

   // Decode the operation into the control word.
   always_comb begin
      push_ctl        = '0;
      push_ctl.col_ok = ({1'b0, idx} < num_cols) && in_store;
      unique case (req_tuser)
         OP_LOAD: begin
            push_ctl.is_load = in_store;
         end
         OP_NONZERO: begin
            push_ctl.is_mac   = 1'b1;
            push_ctl.row_done = req_tlast;
         end
         OP_EMPTY: begin
            push_ctl.row_done = 1'b1;
         end
         default: begin
            push_ctl.col_ok = 1'b0;
         end
      endcase
   end

   // Items that change nothing (unused code, load past the store) are dropped.
   assign keep       = push_ctl.is_load | push_ctl.is_mac | push_ctl.row_done;
   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full && keep;

endmodule

// ===== rtl/smv_fifo.sv =====
// ----------------------------------------------------------------------------
// smv_fifo: item queue
// Small register queue that decouples the front end from the back end so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module smv_fifo
   import smv_pkg::*;
#(
   parameter int DATA_W = 46
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   logic [DATA_W-1:0]     slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots hold payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/smv_back.sv =====
// ----------------------------------------------------------------------------
// smv_back: vector store and multiply-accumulate pipeline
// Pops classified items, reads or writes the vector store, multiplies,
// accumulates with 64-bit saturation, then rounds and clips each finished row
// into the result register.
// ----------------------------------------------------------------------------
module smv_back
   import smv_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int AW          = 10,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fifo_empty,
   input  item_ctl_type           pop_ctl,
   input  logic [AW-1:0]          pop_addr,
   input  logic [VALUE_WIDTH-1:0] pop_value,
   output logic                   fifo_pop,
   input  logic [ROWS_W-1:0]      num_rows,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [15:0] row_index, [47:16] row_value
   output logic [1:0]             rsp_tuser,  // [0] saturated, [1] bad_column
   output logic                   rsp_tlast   // last_row
);

   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int Q_W    = ACC_W - 15;
   localparam logic signed [Q_W-1:0] QMax = (Q_W'(1) <<< (VALUE_WIDTH - 1)) - Q_W'(1);
   localparam logic signed [Q_W-1:0] QMin = -QMax - Q_W'(1);
   localparam logic signed [ACC_W-1:0] AccMax = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] AccMin = {1'b1, {(ACC_W-1){1'b0}}};

   logic adv;

   // Vector store and its registered read port.
   logic [VALUE_WIDTH-1:0] vec_mem [MAX_COLS];
   logic [VALUE_WIDTH-1:0] vec_rd_ff;

   // Multiply stage.
   logic                   s2_valid_ff, s2_valid_in;
   item_ctl_type           s2_ctl_ff;
   logic [VALUE_WIDTH-1:0] s2_value_ff;

   // Accumulate stage.
   logic                   s3_valid_ff, s3_valid_in;
   item_ctl_type           s3_ctl_ff;
   logic [PROD_W-1:0]      s3_prod_ff, s3_prod_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    err_ff, err_in;
   logic [ROW_IDX_W-1:0]    row_cnt_ff, row_cnt_in;
   logic signed [ACC_W:0]   sum_wide;
   logic signed [ACC_W-1:0] sum_sat;
   logic                    err_row;
   logic [ROWS_W-1:0]       last_at;
   logic                    is_last;

   // Finished-row stage.
   logic                    fin_valid_ff, fin_valid_in;
   logic signed [ACC_W-1:0] fin_sum_ff;
   logic                    fin_bad_ff;
   logic                    fin_last_ff;
   logic [ROW_IDX_W-1:0]    fin_row_ff;

   // Rounding and output register.
   logic signed [Q_W-1:0]   q_round;
   logic signed [Q_W-1:0]   q_clip;
   logic                    q_sat;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [1:0]              rsp_user_ff;
   logic                    rsp_last_ff;

   // The whole pipeline moves when the result register can take a transfer.
   assign adv      = !rsp_valid_ff || rsp_tready;
   assign fifo_pop = adv && !fifo_empty;

   // Loads write the store; every other item reads its column.
   always_ff @(posedge clock) begin
      if (fifo_pop && pop_ctl.is_load) begin
         vec_mem[pop_addr] <= pop_value;
      end
      if (fifo_pop) begin
         vec_rd_ff <= vec_mem[pop_addr];
      end
   end

   assign s2_valid_in = fifo_pop;

   // Product of value and vector element; a bad column contributes zero.
   assign s3_valid_in = s2_valid_ff;
   assign s3_prod_in  = (s2_ctl_ff.is_mac && s2_ctl_ff.col_ok) ?
                        PROD_W'($signed(s2_value_ff) * $signed(vec_rd_ff)) : '0;

   // Saturating 64-bit accumulation.
   always_comb begin
      sum_wide = {acc_ff[ACC_W-1], acc_ff}
               + {{(ACC_W + 1 - PROD_W){s3_prod_ff[PROD_W-1]}}, s3_prod_ff};
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? AccMin : AccMax;
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
      err_row = err_ff | (s3_ctl_ff.is_mac & ~s3_ctl_ff.col_ok);
   end

   // Row counter wraps at the effective row count; out-of-range counts mean 65536.
   always_comb begin
      if (num_rows == '0 || num_rows > ROWS_W'(65536)) begin
         last_at = ROWS_W'(65535);
      end else begin
         last_at = num_rows - 1'b1;
      end
      is_last = {1'b0, row_cnt_ff} >= last_at;
   end

   // Accumulator, column error flag and row counter update.
   always_comb begin
      acc_in       = acc_ff;
      err_in       = err_ff;
      row_cnt_in   = row_cnt_ff;
      fin_valid_in = 1'b0;
      if (s3_valid_ff) begin
         if (s3_ctl_ff.row_done) begin
            acc_in       = '0;
            err_in       = 1'b0;
            row_cnt_in   = is_last ? '0 : row_cnt_ff + 1'b1;
            fin_valid_in = 1'b1;
         end else begin
            acc_in = sum_sat;
            err_in = err_row;
         end
      end
   end

   // Round half up to Q16.16 and clip to the signed value range.
   always_comb begin
      q_round = $signed({fin_sum_ff[ACC_W-1], fin_sum_ff[ACC_W-1:16]})
              + $signed({{(Q_W-1){1'b0}}, fin_sum_ff[15]});
      q_sat   = 1'b0;
      q_clip  = q_round;
      if (q_round > QMax) begin
         q_clip = QMax;
         q_sat  = 1'b1;
      end else if (q_round < QMin) begin
         q_clip = QMin;
         q_sat  = 1'b1;
      end
   end

   assign rsp_valid_in = fin_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         row_cnt_ff   <= '0;
      end else if (adv) begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff   <= pop_ctl;
         s2_value_ff <= pop_value;
         s3_ctl_ff   <= s2_ctl_ff;
         s3_prod_ff  <= s3_prod_in;
         if (fin_valid_in) begin
            fin_sum_ff  <= sum_sat;
            fin_bad_ff  <= err_row;
            fin_last_ff <= is_last;
            fin_row_ff  <= row_cnt_ff;
         end
         if (fin_valid_ff) begin
            rsp_data_ff <= {q_clip[FIELD_W-1:0], fin_row_ff};
            rsp_user_ff <= {fin_bad_ff, q_sat};
            rsp_last_ff <= fin_last_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/sparse_matvec_csr.sv =====
// ----------------------------------------------------------------------------
// sparse_matvec_csr: CSR sparse matrix times dense vector
// Loads a dense vector, streams row-ordered nonzeros and returns one rounded,
// saturated Q16.16 dot product per matrix row.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): each transfer is a load of one vector element,
//   a matrix nonzero (req_tlast closes its row) or an empty-row marker.
//   Vector elements must be loaded before any nonzero reads them.
//   Result channel (rsp_*): one transfer per finished row with row index,
//   row value, saturation and bad-column flags; rsp_tlast marks the final row.
//   Configuration (csr_*): num_rows and num_cols, written while idle.
// Timing:
//   One request per cycle is taken whenever the four-entry queue has room.
//   A row result passes through the queue slot, the store read, the multiply,
//   the accumulate and the rounding stage after the transfer that closes the
//   row. Sustained rate is one item per cycle while rsp_tready does not stall.
// Reset and stalls:
//   Reset clears the accumulator, row counter, error flag and queue; both
//   registers return to 1. The vector store is not cleared.
//   While a result waits with rsp_tready low, the back end holds; requests
//   are still taken until the queue fills, then req_tready drops.
// ----------------------------------------------------------------------------
module sparse_matvec_csr
   import smv_pkg::*;
#(
   parameter int MAX_COLS    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [9:0] index, [41:10] value, [47:42] zero
   input  logic [OP_W-1:0]        req_tuser,   // [1:0] operation
   input  logic                   req_tlast,   // row_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] row_index, [47:16] row_value
   output logic [1:0]             rsp_tuser,   // [0] saturated, [1] bad_column
   output logic                   rsp_tlast,   // last_row
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW     = $clog2(MAX_COLS);
   localparam int CTL_W  = $bits(item_ctl_type);
   localparam int ITEM_W = CTL_W + AW + VALUE_WIDTH;

   logic [ROWS_W-1:0]      num_rows_ff;
   logic [COLS_W-1:0]      num_cols_ff;

   logic                   fifo_push;
   logic                   fifo_pop;
   logic                   fifo_full;
   logic                   fifo_empty;
   item_ctl_type           push_ctl;
   logic [AW-1:0]          push_addr;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [ITEM_W-1:0]      pop_data;
   item_ctl_type           pop_ctl;
   logic [AW-1:0]          pop_addr;
   logic [VALUE_WIDTH-1:0] pop_value;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= ROWS_W'(1);
         num_cols_ff <= COLS_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            CSR_NUM_COLS: num_cols_ff <= csr_wdata[COLS_W-1:0];
            default: begin
               num_rows_ff <= num_rows_ff;
            end
         endcase
      end
   end

   // Front end: decode and classify.
   smv_front #(
      .MAX_COLS    (MAX_COLS),
      .AW          (AW),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .num_cols   (num_cols_ff),
      .fifo_full  (fifo_full),
      .push       (fifo_push),
      .push_ctl   (push_ctl),
      .push_addr  (push_addr),
      .push_value (push_value)
   );

   // Queue between front and back end.
   smv_fifo #(
      .DATA_W (ITEM_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data ({push_ctl, push_addr, push_value}),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   assign pop_ctl   = pop_data[ITEM_W-1 -: CTL_W];
   assign pop_addr  = pop_data[VALUE_WIDTH +: AW];
   assign pop_value = pop_data[VALUE_WIDTH-1:0];

   // Back end: store, multiply-accumulate and result register.
   smv_back #(
      .MAX_COLS    (MAX_COLS),
      .AW          (AW),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .pop_ctl    (pop_ctl),
      .pop_addr   (pop_addr),
      .pop_value  (pop_value),
      .fifo_pop   (fifo_pop),
      .num_rows   (num_rows_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // The front end never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("queue push while full");

   // The back end never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_empty)
      else $error("queue pop while empty");

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
